FILE: hdl/vxd_pkg.sv
// Shared types and constants for the xor chain font decoder.
// No dependencies; used by vfont_xor_chain_decoder.
`default_nettype none

package vxd_pkg;

   localparam logic       KIND_LOAD = 1'b0;
   localparam logic       KIND_READ = 1'b1;

   localparam logic [2:0] STS_LOADED    = 3'd0;
   localparam logic [2:0] STS_OK        = 3'd1;
   localparam logic [2:0] STS_SHORT     = 3'd2;
   localparam logic [2:0] STS_TAG_BAD   = 3'd3;
   localparam logic [2:0] STS_SALT_BAD  = 3'd4;
   localparam logic [2:0] STS_OVERFLOW  = 3'd5;
   localparam logic [2:0] STS_BAD_READ  = 3'd6;

   localparam logic [7:0] KEY_BASE = 8'hA7;
   localparam logic [2:0] TAG_LAST = 3'd5;

   typedef struct packed {
      logic        kind;
      logic [7:0]  byte_value;
      logic        last;
      logic [11:0] read_index;
   } req_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [12:0] payload_length;
      logic [2:0]  status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_TAG_RD,
      ST_TAG_USE,
      ST_SALT_RD,
      ST_SALT_USE,
      ST_FOLD_RD,
      ST_FOLD_USE,
      ST_PRV_RD,
      ST_PRV_USE,
      ST_DAT_RD,
      ST_DAT_USE,
      ST_PUT
   } state_type;

   // trailing tag "VFONT1"
   function automatic logic [7:0] tag_byte(input logic [2:0] k);
      logic [7:0] b;
      unique case (k)
         3'd0:    b = 8'h56;
         3'd1:    b = 8'h46;
         3'd2:    b = 8'h4F;
         3'd3:    b = 8'h4E;
         3'd4:    b = 8'h54;
         3'd5:    b = 8'h31;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/vfont_xor_chain_decoder.sv
// Top level: loads an encoded font file, checks tag and salt, decodes reads.
// Depends on vxd_pkg and vxd_ram.
//
//  channel | dir | payload         | beat
//  req     | in  | vxd_pkg::req_type | one load byte or one read request
//  rsp     | out | vxd_pkg::rsp_type | one result per request
//
// A load that is not last, like a bad read, is answered at acceptance. A last
// load then reads the tag, the salt count byte and each folded salt byte (up to
// 254), all paced by the single read port of the raw store. A good read reads
// the previous byte (for an index above 0), then the byte.
// Reset clears state, counts, key, length and flags, not the raw store.
// A result waiting on rsp parks the next result, which then holds req_ready low.
`default_nettype none

module vfont_xor_chain_decoder #(
   parameter int DEPTH = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire vxd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output vxd_pkg::rsp_type      rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = (CW > 8) ? CW : 8;
   localparam int IW = (CW > 12) ? CW : 12;

   vxd_pkg::state_type state_ff, state_in;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    key_ff, key_in;
   logic [CW-1:0] dlen_ff, dlen_in;
   logic          dready_ff, dready_in;
   logic          betw_ff, betw_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [2:0]    k_ff, k_in;
   logic [7:0]    rem_ff, rem_in;
   logic [7:0]    acc_ff, acc_in;
   logic [CW-1:0] sat_ff, sat_in;
   logic [7:0]    rkey_ff, rkey_in;
   vxd_pkg::rsp_type res_ff, res_in;
   vxd_pkg::rsp_type rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          req_fire, slot_free, is_load, full, rd_bad, push_now;
   logic [CW-1:0] cbase;
   logic          obase;
   logic          mem_wr, mem_rd;
   logic [7:0]    rd_data;
   logic          tag_ok, salt_bad, short_file;
   logic [CW-1:0] tag_at, salt_at;
   logic [7:0]    fold_key;
   vxd_pkg::rsp_type imm_res;

   assign req_ready  = (state_ff == vxd_pkg::ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign is_load    = (req_data.kind == vxd_pkg::KIND_LOAD);
   assign cbase      = betw_ff ? '0 : cnt_ff;
   assign obase      = betw_ff ? 1'b0 : ovf_ff;
   assign full       = (cbase == CW'(DEPTH));
   assign rd_bad     = !dready_ff || (IW'(req_data.read_index) >= IW'(dlen_ff));
   assign mem_wr     = req_fire && is_load && !full;
   assign tag_at     = cnt_ff - CW'(6);
   assign short_file = (cnt_ff <= CW'(6));
   assign tag_ok     = (rd_data == vxd_pkg::tag_byte(k_ff));
   assign salt_bad   = (rd_data == 8'd0) || (SW'(rd_data) > SW'(tag_at));
   assign salt_at    = CW'(SW'(tag_at) - SW'(rd_data));
   assign fold_key   = acc_ff ^ (rd_data + vxd_pkg::KEY_BASE);
   assign mem_rd     = (state_ff == vxd_pkg::ST_TAG_RD) || (state_ff == vxd_pkg::ST_SALT_RD) ||
                       (state_ff == vxd_pkg::ST_FOLD_RD) || (state_ff == vxd_pkg::ST_PRV_RD) ||
                       (state_ff == vxd_pkg::ST_DAT_RD);
   // results known at acceptance: plain loads and bad reads
   assign push_now   = req_fire && ((is_load && !req_data.last) || (!is_load && rd_bad));
   assign imm_res    = '{data_byte: 8'd0, payload_length: 13'd0,
                         status: is_load ? vxd_pkg::STS_LOADED : vxd_pkg::STS_BAD_READ};

   vxd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_raw (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (AW'(cbase)),
      .wr_data (req_data.byte_value),
      .rd_en   (mem_rd),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vxd_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (is_load && req_data.last) begin
                  state_in = vxd_pkg::ST_CHECK;
               end else if (push_now) begin
                  state_in = slot_free ? vxd_pkg::ST_IDLE : vxd_pkg::ST_PUT;
               end else if (req_data.read_index == 12'd0) begin
                  state_in = vxd_pkg::ST_DAT_RD;
               end else begin
                  state_in = vxd_pkg::ST_PRV_RD;
               end
            end
         end
         vxd_pkg::ST_CHECK:
            state_in = (ovf_ff || short_file) ? vxd_pkg::ST_PUT : vxd_pkg::ST_TAG_RD;
         vxd_pkg::ST_TAG_RD:  state_in = vxd_pkg::ST_TAG_USE;
         vxd_pkg::ST_TAG_USE: begin
            priority if (!tag_ok) state_in = vxd_pkg::ST_PUT;
            else if (k_ff == vxd_pkg::TAG_LAST) state_in = vxd_pkg::ST_SALT_RD;
            else state_in = vxd_pkg::ST_TAG_RD;
         end
         vxd_pkg::ST_SALT_RD:  state_in = vxd_pkg::ST_SALT_USE;
         vxd_pkg::ST_SALT_USE:
            state_in = (salt_bad || rd_data == 8'd1) ? vxd_pkg::ST_PUT : vxd_pkg::ST_FOLD_RD;
         vxd_pkg::ST_FOLD_RD:  state_in = vxd_pkg::ST_FOLD_USE;
         vxd_pkg::ST_FOLD_USE:
            state_in = (rem_ff == 8'd1) ? vxd_pkg::ST_PUT : vxd_pkg::ST_FOLD_RD;
         vxd_pkg::ST_PRV_RD:  state_in = vxd_pkg::ST_PRV_USE;
         vxd_pkg::ST_PRV_USE: state_in = vxd_pkg::ST_DAT_RD;
         vxd_pkg::ST_DAT_RD:  state_in = vxd_pkg::ST_DAT_USE;
         vxd_pkg::ST_DAT_USE: state_in = vxd_pkg::ST_PUT;
         vxd_pkg::ST_PUT:     state_in = slot_free ? vxd_pkg::ST_IDLE : vxd_pkg::ST_PUT;
         default:             state_in = vxd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      key_in       = key_ff;
      dlen_in      = dlen_ff;
      dready_in    = dready_ff;
      betw_in      = betw_ff;
      ptr_in       = ptr_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      rkey_in      = rkey_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         vxd_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (is_load) begin
                  cnt_in    = full ? cbase : cbase + CW'(1);
                  ovf_in    = obase || full;
                  dready_in = betw_ff ? 1'b0 : dready_ff;
                  betw_in   = req_data.last;
               end else if (req_data.read_index == 12'd0) begin
                  rkey_in = key_ff;
                  ptr_in  = AW'(req_data.read_index);
               end else begin
                  ptr_in = AW'(req_data.read_index - 12'd1);
               end
               if (push_now) begin
                  if (slot_free) begin
                     rsp_in       = imm_res;
                     rsp_valid_in = 1'b1;
                  end else begin
                     res_in = imm_res;
                  end
               end
            end
         end
         vxd_pkg::ST_CHECK: begin
            res_in = '{data_byte: 8'd0, payload_length: 13'd0,
                       status: ovf_ff ? vxd_pkg::STS_OVERFLOW : vxd_pkg::STS_SHORT};
            ptr_in = AW'(tag_at);
            k_in   = 3'd0;
         end
         vxd_pkg::ST_TAG_USE: begin
            res_in = '{data_byte: 8'd0, payload_length: 13'd0, status: vxd_pkg::STS_TAG_BAD};
            if (k_ff == vxd_pkg::TAG_LAST) begin
               ptr_in = AW'(cnt_ff - CW'(7));
            end else begin
               ptr_in = ptr_ff + AW'(1);
               k_in   = k_ff + 3'd1;
            end
         end
         vxd_pkg::ST_SALT_USE: begin
            sat_in = salt_at;
            if (salt_bad) begin
               res_in = '{data_byte: 8'd0, payload_length: 13'd0,
                          status: vxd_pkg::STS_SALT_BAD};
            end else if (rd_data == 8'd1) begin
               key_in    = vxd_pkg::KEY_BASE;
               dlen_in   = salt_at;
               dready_in = 1'b1;
               res_in    = '{data_byte: 8'd0, payload_length: 13'(salt_at),
                             status: vxd_pkg::STS_OK};
            end else begin
               ptr_in = AW'(salt_at);
               rem_in = rd_data - 8'd1;
               acc_in = vxd_pkg::KEY_BASE;
            end
         end
         vxd_pkg::ST_FOLD_USE: begin
            acc_in = fold_key;
            ptr_in = ptr_ff + AW'(1);
            rem_in = rem_ff - 8'd1;
            if (rem_ff == 8'd1) begin
               key_in    = fold_key;
               dlen_in   = sat_ff;
               dready_in = 1'b1;
               res_in    = '{data_byte: 8'd0, payload_length: 13'(sat_ff),
                             status: vxd_pkg::STS_OK};
            end
         end
         vxd_pkg::ST_PRV_USE: begin
            rkey_in = rd_data + vxd_pkg::KEY_BASE;
            ptr_in  = ptr_ff + AW'(1);
         end
         vxd_pkg::ST_DAT_USE: begin
            res_in = '{data_byte: rd_data ^ rkey_ff, payload_length: 13'd0,
                       status: vxd_pkg::STS_OK};
         end
         vxd_pkg::ST_PUT: begin
            if (slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vxd_pkg::ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         key_ff       <= vxd_pkg::KEY_BASE;
         dlen_ff      <= '0;
         dready_ff    <= 1'b0;
         betw_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         key_ff       <= key_in;
         dlen_ff      <= dlen_in;
         dready_ff    <= dready_in;
         betw_ff      <= betw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff  <= ptr_in;
      k_ff    <= k_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      sat_ff  <= sat_in;
      rkey_ff <= rkey_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("load count beyond store depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (cnt_ff == CW'(DEPTH)))
      else $error("overflow flagged with store not full");

   a_dlen_fits: assert property (@(posedge clock) disable iff (reset)
      dready_ff |-> (dlen_ff <= CW'(DEPTH - 7)))
      else $error("decoded length leaves no room for salt and tag");

   a_put_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vxd_pkg::ST_PUT && slot_free) |=>
         (rsp_valid_ff && state_ff == vxd_pkg::ST_IDLE))
      else $error("pending result not moved to output beat");

endmodule

`default_nettype wire

FILE: hdl/vxd_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none

module vxd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
